// File: sv/cmst_pkg.sv
// cmst_pkg: types and codes for the connection-management state tracker
// request/response structs, flow table record, sequencer states
// no dependencies
package cmst_pkg;

  localparam int unsigned TableEntriesDef = 64;

  localparam logic [2:0] CMD_REQ  = 3'd0;
  localparam logic [2:0] CMD_REJ  = 3'd1;
  localparam logic [2:0] CMD_REP  = 3'd2;
  localparam logic [2:0] CMD_RTU  = 3'd3;
  localparam logic [2:0] CMD_DREQ = 3'd4;
  localparam logic [2:0] CMD_DREP = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNEXP   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOKEY   = 3'd4;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_EST     = 3'd1;
  localparam logic [2:0] EV_BADQPN  = 3'd2;
  localparam logic [2:0] EV_DUPQP   = 3'd3;
  localparam logic [2:0] EV_DISCONN = 3'd4;

  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_REQ_SENT     = 4'd1;
  localparam logic [3:0] PH_REQ_RCVD     = 4'd2;
  localparam logic [3:0] PH_MRA_REQ_SENT = 4'd3;
  localparam logic [3:0] PH_MRA_REQ_RCVD = 4'd4;
  localparam logic [3:0] PH_REP_SENT     = 4'd5;
  localparam logic [3:0] PH_REP_RCVD     = 4'd6;
  localparam logic [3:0] PH_MRA_REP_SENT = 4'd7;
  localparam logic [3:0] PH_MRA_REP_RCVD = 4'd8;
  localparam logic [3:0] PH_ESTABLISHED  = 4'd9;
  localparam logic [3:0] PH_DREQ_SENT    = 4'd10;
  localparam logic [3:0] PH_DREQ_RCVD    = 4'd11;
  localparam logic [3:0] PH_TIMEWAIT     = 4'd12;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        from_net;
    logic [31:0] msg_local_id;
    logic [31:0] msg_remote_id;
    logic [23:0] msg_qpn;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } cm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  event_res;
    logic [3:0]  conn_state;
    logic [5:0]  entry_index;
    logic [23:0] own_qpn;
    logic [23:0] peer_qpn;
    logic [31:0] peer_address;
  } cm_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] own_id;
    logic [31:0] peer_ip;
    logic [31:0] peer_id;
    logic [3:0]  phase;
    logic [23:0] own_qpn;
    logic [23:0] peer_qpn;
    logic        in_qp;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_PICK, S_APPLY, S_QSCAN, S_DONE
  } state_e;

endpackage

// File: sv/cm_connection_state_tracker.sv
// cm_connection_state_tracker: connection-management flow tracker, top level
// uses cmst_pkg and cmst_table
//
// usage:
//   in channel  (in_valid_i / in_ready_o / in_req_i): one parsed cm message per request
//   out channel (out_valid_o / out_ready_i / out_rsp_o): one response per request
//   after reset the table is swept clear, one entry a cycle, and in_ready_o
//   stays low during that sweep
//   each request with a known type and a key scans the whole table once through
//   the single read port; a ready-to-use that passes its qpn checks scans again
//   for a duplicate qpn; unknown types and keyless messages answer without a scan
//   one request is in work at a time; in_ready_o is high only when idle
//   the response register holds a finished response while the next request is
//   accepted; a stalled receiver holds the sequencer before it writes a new one
module cm_connection_state_tracker import cmst_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  cm_req_t in_req_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cm_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;

  logic [2:0]  cmd_q;
  logic        net_q;
  logic [31:0] oid_q, pid_q, pids_q, pip_q;
  logic        pidl_nz_q;
  logic [23:0] qpn_q;

  logic            own_hit_q, peer_hit_q, free_hit_q, dup_q;
  logic [IdxW-1:0] own_idx_q, peer_idx_q, free_idx_q;

  logic [IdxW-1:0] e_q, e_d;
  logic            alloc_q, alloc_d, link_own_q, link_own_d, full_d;
  entry_t          rec_q, rec_new, base;
  cm_rsp_t         res_q, res_new;
  logic            est_scan;

  logic            out_valid_q;
  cm_rsp_t         out_q;

  logic            we;
  logic [IdxW-1:0] waddr, raddr, sidx;
  entry_t          wdata, rdata;

  logic        in_acc;
  logic [31:0] a_oid, a_pid, a_pip, a_pidl;
  logic        a_unknown, a_nokey;
  logic        proc, last, m_own, m_peer, m_free, m_dup, dup_final;

  cmst_table #(.TableEntries(TableEntries), .IdxW(IdxW)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // request decode
  always_comb begin
    a_oid = in_req_i.from_net ? in_req_i.msg_remote_id : in_req_i.msg_local_id;
    a_pid = in_req_i.from_net ? in_req_i.msg_local_id : in_req_i.msg_remote_id;
    a_pip = in_req_i.from_net ? in_req_i.src_ip : in_req_i.dst_ip;
    if (in_req_i.cmd == CMD_REQ) begin
      if (in_req_i.from_net) begin
        a_oid = '0;
      end else begin
        a_pid = '0;
      end
    end
    if ((in_req_i.cmd == CMD_REJ) || (in_req_i.cmd == CMD_REQ && in_req_i.from_net) ||
        (in_req_i.cmd == CMD_REP && !in_req_i.from_net)) begin
      a_pidl = a_pid;
    end else begin
      a_pidl = '0;
    end
    a_unknown = (in_req_i.cmd > CMD_DREP);
    a_nokey   = (a_oid == '0) && (a_pidl == '0);
  end

  // scan matching
  assign proc = ((state_q == S_SCAN) || (state_q == S_QSCAN)) && (cnt_q != '0);
  assign last = (cnt_q == CntW'(TableEntries));
  assign sidx = IdxW'(cnt_q - CntW'(1));
  assign m_own  = rdata.valid && (oid_q != '0) && (rdata.own_id == oid_q);
  assign m_peer = rdata.valid && (pids_q != '0) && (rdata.peer_id == pids_q) &&
                  (rdata.peer_ip == pip_q);
  assign m_free = !rdata.valid;
  assign m_dup  = rdata.valid && rdata.in_qp && (rdata.own_qpn == rec_q.own_qpn) &&
                  (sidx != e_q);
  assign dup_final = dup_q || (proc && m_dup);

  // slot choice
  always_comb begin
    e_d        = free_idx_q;
    alloc_d    = 1'b0;
    link_own_d = 1'b0;
    full_d     = 1'b0;
    if (oid_q != '0 && own_hit_q) begin
      e_d = own_idx_q;
    end else if (pidl_nz_q && peer_hit_q) begin
      e_d        = peer_idx_q;
      link_own_d = (oid_q != '0);
    end else if (free_hit_q) begin
      alloc_d = 1'b1;
    end else begin
      full_d = 1'b1;
    end
  end

  // transition for the chosen slot
  always_comb begin
    base = rdata;
    if (alloc_q) begin
      base         = '0;
      base.valid   = 1'b1;
      base.own_id  = oid_q;
      if (pidl_nz_q) begin
        base.peer_ip = pip_q;
        base.peer_id = pids_q;
      end
    end else if (link_own_q) begin
      base.own_id = oid_q;
    end
    rec_new  = base;
    est_scan = 1'b0;
    res_new  = '0;
    res_new.status = ST_OK;
    res_new.event_res = EV_NONE;
    case (cmd_q)
      CMD_REQ: begin
        if (!net_q && (base.phase == PH_IDLE || base.phase == PH_REQ_SENT)) begin
          rec_new.phase   = PH_REQ_SENT;
          rec_new.own_qpn = qpn_q;
        end else if (net_q && (base.phase == PH_IDLE || base.phase == PH_REQ_RCVD)) begin
          rec_new.phase    = PH_REQ_RCVD;
          rec_new.peer_qpn = qpn_q;
        end else begin
          res_new.status = ST_UNEXP;
        end
      end
      CMD_REJ: begin
        if ((!net_q && base.phase <= PH_MRA_REP_RCVD) ||
            (net_q && base.phase <= PH_DREQ_SENT && base.phase != PH_REQ_RCVD)) begin
          rec_new.valid = 1'b0;
          rec_new.phase = PH_IDLE;
          if (base.in_qp) begin
            if (base.own_qpn == '0 || base.peer_qpn == '0) begin
              res_new.event_res = EV_BADQPN;
            end else begin
              rec_new.in_qp     = 1'b0;
              res_new.event_res = EV_DISCONN;
            end
          end
        end else begin
          res_new.status = ST_UNEXP;
        end
      end
      CMD_REP: begin
        if (!net_q && (base.phase == PH_REQ_RCVD || base.phase == PH_MRA_REQ_SENT)) begin
          rec_new.phase   = PH_REP_SENT;
          rec_new.own_qpn = qpn_q;
          if (pid_q != '0 && !peer_hit_q) begin
            rec_new.peer_ip = pip_q;
            rec_new.peer_id = pid_q;
          end
        end else if (!net_q && base.phase == PH_REP_SENT) begin
          rec_new = base;
        end else if (net_q && (base.phase == PH_REQ_SENT ||
                               base.phase == PH_MRA_REQ_RCVD)) begin
          rec_new.phase    = PH_REP_RCVD;
          rec_new.peer_qpn = qpn_q;
          if (pid_q != '0 && !peer_hit_q) begin
            rec_new.peer_ip = pip_q;
            rec_new.peer_id = pid_q;
          end
        end else begin
          res_new.status = ST_UNEXP;
        end
      end
      CMD_RTU: begin
        if ((!net_q && (base.phase == PH_REP_RCVD || base.phase == PH_MRA_REP_SENT)) ||
            (net_q && (base.phase == PH_REP_SENT || base.phase == PH_MRA_REP_RCVD))) begin
          rec_new.phase = PH_ESTABLISHED;
          if (base.own_qpn == '0 || base.peer_qpn == '0) begin
            res_new.event_res = EV_BADQPN;
          end else begin
            est_scan = 1'b1;
          end
        end else begin
          res_new.status = ST_UNEXP;
        end
      end
      CMD_DREQ: begin
        if (!net_q && (base.phase == PH_IDLE || base.phase == PH_ESTABLISHED ||
                       base.phase == PH_DREQ_SENT || base.phase == PH_DREQ_RCVD)) begin
          rec_new.phase = PH_DREQ_SENT;
        end else if (net_q && (base.phase == PH_REP_SENT ||
                               base.phase == PH_MRA_REP_RCVD ||
                               base.phase == PH_ESTABLISHED ||
                               base.phase == PH_DREQ_SENT ||
                               base.phase == PH_DREQ_RCVD ||
                               base.phase == PH_TIMEWAIT)) begin
          rec_new.phase = PH_DREQ_RCVD;
        end else begin
          res_new.status = ST_UNEXP;
        end
      end
      default: begin
        if (base.phase == PH_DREQ_SENT || base.phase == PH_DREQ_RCVD) begin
          rec_new.valid = 1'b0;
          rec_new.phase = PH_IDLE;
          if (base.in_qp) begin
            if (base.own_qpn == '0 || base.peer_qpn == '0) begin
              res_new.event_res = EV_BADQPN;
            end else begin
              rec_new.in_qp     = 1'b0;
              res_new.event_res = EV_DISCONN;
            end
          end
        end else begin
          res_new.status = ST_UNEXP;
        end
      end
    endcase
    res_new.conn_state   = rec_new.valid ? rec_new.phase : PH_IDLE;
    res_new.entry_index  = 6'(e_q);
    res_new.own_qpn      = rec_new.own_qpn;
    res_new.peer_qpn     = rec_new.peer_qpn;
    res_new.peer_address = rec_new.peer_ip;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q == CntW'(TableEntries - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_d = (a_unknown || a_nokey) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (last) state_d = S_PICK;
      end
      S_PICK: begin
        state_d = full_d ? S_DONE : S_APPLY;
      end
      S_APPLY: begin
        state_d = est_scan ? S_QSCAN : S_DONE;
      end
      S_QSCAN: begin
        if (last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = e_q;
    wdata = rec_new;
    raddr = IdxW'(cnt_q);
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = IdxW'(cnt_q);
        wdata = '0;
      end
      S_PICK: begin
        raddr = e_d;
      end
      S_APPLY: begin
        we = 1'b1;
      end
      S_QSCAN: begin
        we          = last && !dup_final;
        wdata       = rec_q;
        wdata.in_qp = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: cnt_q <= cnt_q + CntW'(1);
        S_SCAN, S_QSCAN: cnt_q <= last ? '0 : cnt_q + CntW'(1);
        default: cnt_q <= '0;
      endcase
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q      <= in_req_i.cmd;
      net_q      <= in_req_i.from_net;
      oid_q      <= a_oid;
      pid_q      <= a_pid;
      pids_q     <= (in_req_i.cmd == CMD_REP) ? a_pid : a_pidl;
      pidl_nz_q  <= (a_pidl != '0);
      pip_q      <= a_pip;
      qpn_q      <= in_req_i.msg_qpn;
      own_hit_q  <= 1'b0;
      peer_hit_q <= 1'b0;
      free_hit_q <= 1'b0;
      dup_q      <= 1'b0;
      res_q      <= '{status: (a_unknown ? ST_UNKNOWN : ST_NOKEY), default: '0};
    end
    if (proc && state_q == S_SCAN) begin
      if (m_own && !own_hit_q) begin
        own_hit_q <= 1'b1;
        own_idx_q <= sidx;
      end
      if (m_peer && !peer_hit_q) begin
        peer_hit_q <= 1'b1;
        peer_idx_q <= sidx;
      end
      if (m_free && !free_hit_q) begin
        free_hit_q <= 1'b1;
        free_idx_q <= sidx;
      end
    end
    if (proc && state_q == S_QSCAN && m_dup) begin
      dup_q <= 1'b1;
    end
    if (state_q == S_PICK) begin
      e_q        <= e_d;
      alloc_q    <= alloc_d;
      link_own_q <= link_own_d;
      if (full_d) begin
        res_q <= '{status: ST_FULL, default: '0};
      end
    end
    if (state_q == S_APPLY) begin
      rec_q <= rec_new;
      res_q <= res_new;
    end
    if (state_q == S_QSCAN && last) begin
      res_q.event_res <= dup_final ? EV_DUPQP : EV_EST;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we)
    else $error("table written while idle");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready right after an accepted request");
  a_unknown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_UNKNOWN |->
      out_rsp_o.event_res == EV_NONE && out_rsp_o.conn_state == PH_IDLE)
    else $error("unknown type response carries data");
  a_disconn_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.event_res == EV_DISCONN |-> out_rsp_o.conn_state == PH_IDLE)
    else $error("disconnected flow not erased");
`endif

endmodule

// File: sv/cmst_table.sv
// cmst_table: flow table storage, one write port and one registered read port
// uses entry_t from cmst_pkg
module cmst_table import cmst_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef,
  parameter int unsigned IdxW         = $clog2(TableEntries)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [TableEntries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
